FILE: design/lagrangian_lower_bound_accumulator_defines.svh
// assertion macros used by the top-level accumulator module
// expects clk and rst_n in the scope of each use
`ifndef LAGRANGIAN_LOWER_BOUND_ACCUMULATOR_DEFINES_SVH
`define LAGRANGIAN_LOWER_BOUND_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define LLBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define LLBA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/llba_pkg.sv
// types and constants of the lagrangian lower bound accumulator
// no dependencies
package llba_pkg;

    localparam int GRID_SIZE = 4;
    localparam int GRID_W    = 2;
    localparam int NUM_LANES = 3;
    localparam int COST_W    = 32;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 4;
    localparam int PFX_W     = 13;
    localparam int SCORE_W   = 64;
    localparam int SUM_W     = 77;
    localparam int STATUS_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q_FACTOR  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MU_BASE   = 4'd4;

    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_BAD_CFG   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_ROW_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_PFX   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_SCORE_OVF = 3'd4;
    localparam logic [STATUS_W-1:0] STS_BOUND_OVF = 3'd5;
    localparam logic [STATUS_W-1:0] STS_TOO_FEW   = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [GRID_W-1:0]  k;
        logic [SCORE_W-1:0] score;
        logic               ovf;
    } lane_res_t;

    typedef struct packed {
        logic               valid;
        logic [GRID_W-1:0]  k;
        logic [SCORE_W-1:0] best;
        logic               ovf;
    } merge_res_t;

endpackage

FILE: design/llba_lane.sv
// one method lane: pipelined score q*c -/+ mu*c*factor with int64 range check
// depends on llba_pkg
module llba_lane
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              issue,
    input  logic [llba_pkg::GRID_W-1:0]       issue_k,
    input  logic                              add_term,
    input  logic [llba_pkg::COST_W-1:0]       cost,
    input  logic [llba_pkg::CFG_W-1:0]        mu,
    input  logic [llba_pkg::CFG_W-1:0]        q_factor,
    input  logic [31:0]                       factor,
    output llba_pkg::lane_res_t               res
);

    localparam int DEPTH = 5;

    logic [DEPTH-1:0]                 vld_reg;
    logic [llba_pkg::GRID_W-1:0]      k_reg [DEPTH];

    logic [63:0]  pm_lo_reg, qa_lo_reg;
    logic [62:0]  pm_hi_reg, qa_hi_reg;
    logic [94:0]  p_reg, a2_reg, a3_reg, a4_reg;
    logic [63:0]  b0_reg, b1_reg;
    logic [62:0]  b2_reg;
    logic [126:0] b_reg;
    logic [128:0] v;
    logic [63:0]  score_reg;
    logic         ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], issue};
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg[0] <= issue_k;
        for (int i = 1; i < DEPTH; i++)
        begin
            k_reg[i] <= k_reg[i-1];
        end
    end

    assign v = add_term ? (129'(a4_reg) + 129'(b_reg)) : (129'(a4_reg) - 129'(b_reg));

    always_ff @(posedge clk)
    begin
        pm_lo_reg <= 64'(mu[31:0]) * 64'(cost);
        pm_hi_reg <= 63'(mu[62:32]) * 63'(cost);
        qa_lo_reg <= 64'(q_factor[31:0]) * 64'(cost);
        qa_hi_reg <= 63'(q_factor[62:32]) * 63'(cost);
        p_reg     <= 95'(pm_lo_reg) + {pm_hi_reg, 32'd0};
        a2_reg    <= 95'(qa_lo_reg) + {qa_hi_reg, 32'd0};
        b0_reg    <= 64'(p_reg[31:0]) * 64'(factor);
        b1_reg    <= 64'(p_reg[63:32]) * 64'(factor);
        b2_reg    <= 63'(p_reg[94:64]) * 63'(factor);
        a3_reg    <= a2_reg;
        b_reg     <= 127'(b0_reg) + 127'({b1_reg, 32'd0}) + {b2_reg, 64'd0};
        a4_reg    <= a3_reg;
        score_reg <= v[63:0];
        ovf_reg   <= !((v[128:63] == '0) || (v[128:63] == '1));
    end

    assign res.valid = vld_reg[DEPTH-1];
    assign res.k     = k_reg[DEPTH-1];
    assign res.score = score_reg;
    assign res.ovf   = ovf_reg;

endmodule

FILE: design/llba_merge.sv
// merging stage: signed minimum over the active lanes, overflow from any of them
// depends on llba_pkg
module llba_merge
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  llba_pkg::lane_res_t                 lane_res [llba_pkg::NUM_LANES],
    input  logic [llba_pkg::NUM_LANES-1:0]      active,
    output llba_pkg::merge_res_t                merged
);

    logic                          found;
    logic [llba_pkg::SCORE_W-1:0]  best;
    logic                          ovf_any;
    logic                          vld_reg;
    logic [llba_pkg::GRID_W-1:0]   k_reg;
    logic [llba_pkg::SCORE_W-1:0]  best_reg;
    logic                          ovf_reg;

    always_comb
    begin
        found   = 1'b0;
        best    = '0;
        ovf_any = 1'b0;
        for (int m = 0; m < llba_pkg::NUM_LANES; m++)
        begin
            if (active[m])
            begin
                ovf_any = ovf_any | lane_res[m].ovf;
                if (!found || ($signed(lane_res[m].score) < $signed(best)))
                begin
                    best = lane_res[m].score;
                end
                found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= lane_res[0].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= lane_res[0].k;
        best_reg <= best;
        ovf_reg  <= ovf_any;
    end

    assign merged.valid = vld_reg;
    assign merged.k     = k_reg;
    assign merged.best  = best_reg;
    assign merged.ovf   = ovf_reg;

endmodule

FILE: design/lagrangian_lower_bound_accumulator.sv
// top level: configuration, row sequencer, wide per-multiplier sums, result register
// depends on llba_pkg, llba_lane, llba_merge and the defines header
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | cost_a..c, has_a..c, fixed_method, last_row
//  out     | output    | out_valid / out_stall| bound_0..3, status
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// a row goes through: four grid multipliers issued one per cycle into three
// method lanes, a six-register lane and merge pipeline, then the commit state
// the result register holds a finished result while the next row is taken
// a last row waits in commit only if the previous result is still held
// rst_n clears control state, sums, counters and configuration
`include "lagrangian_lower_bound_accumulator_defines.svh"

module lagrangian_lower_bound_accumulator
#(
    parameter int ROW_CAPACITY = 4096,
    parameter int COST_BITS    = 32
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [llba_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [llba_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [31:0]                            cost_a,
    input  logic [31:0]                            cost_b,
    input  logic [31:0]                            cost_c,
    input  logic                                   has_a,
    input  logic                                   has_b,
    input  logic                                   has_c,
    input  logic [1:0]                             fixed_method,
    input  logic                                   last_row,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [63:0]                     bound_0,
    output logic signed [63:0]                     bound_1,
    output logic signed [63:0]                     bound_2,
    output logic signed [63:0]                     bound_3,
    output logic [llba_pkg::STATUS_W-1:0]          status
);

    localparam int GRID   = llba_pkg::GRID_SIZE;
    localparam int GW     = llba_pkg::GRID_W;
    localparam int NL     = llba_pkg::NUM_LANES;
    localparam int RIDX_W = $clog2(ROW_CAPACITY + 1);
    localparam int CMP_W  = (RIDX_W > llba_pkg::PFX_W) ? RIDX_W : llba_pkg::PFX_W;
    localparam logic [31:0] COST_MASK =
        (COST_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << COST_BITS) - 64'd1);

    llba_pkg::state_t state_reg, state_next;

    logic [31:0]                   thr_reg, scale_reg;
    logic [llba_pkg::CFG_W-1:0]    q_reg;
    logic [llba_pkg::PFX_W-1:0]    pfx_reg;
    logic [llba_pkg::CFG_W-1:0]    mu_reg [GRID];

    logic [GW:0]                   issue_cnt_reg;
    logic [31:0]                   cost_reg [NL];
    logic [NL-1:0]                 has_reg;
    logic [1:0]                    fm_reg;
    logic                          last_reg, prefix_reg, too_many_reg, row_ovf_reg;
    logic [llba_pkg::STATUS_W-1:0] pre_err_reg;
    logic [63:0]                   score_reg [GRID];

    logic [llba_pkg::SUM_W-1:0]    sum_reg [GRID];
    logic [llba_pkg::SUM_W-1:0]    sum_next [GRID];
    logic [RIDX_W-1:0]             row_idx_reg, row_idx_next;
    logic [llba_pkg::STATUS_W-1:0] first_err_reg, first_err_next;

    logic                          out_valid_reg;
    logic [63:0]                   bound_reg [GRID];
    logic [llba_pkg::STATUS_W-1:0] status_reg;

    logic                          in_acc, out_acc, issue, commit_go, commit;
    logic [NL-1:0]                 has_in, active;
    logic                          prefix_in, bad_pfx, bad_cfg;
    logic [llba_pkg::STATUS_W-1:0] pre_err_in, row_err, status_c;
    logic [NL-1:0]                 fm_sel;
    logic [31:0]                   fac_ab;
    logic [31:0]                   cost_in [NL];

    llba_pkg::lane_res_t           lane_res [NL];
    llba_pkg::merge_res_t          merged;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= '0;
            scale_reg <= 32'd1;
            q_reg     <= 63'd1;
            pfx_reg   <= '0;
            for (int k = 0; k < GRID; k++)
            begin
                mu_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                llba_pkg::REG_THRESHOLD: thr_reg   <= cfg_data[31:0];
                llba_pkg::REG_SCALE:     scale_reg <= cfg_data[31:0];
                llba_pkg::REG_Q_FACTOR:  q_reg     <= cfg_data;
                llba_pkg::REG_PREFIX:    pfx_reg   <= cfg_data[llba_pkg::PFX_W-1:0];
                default:
                begin
                    for (int k = 0; k < GRID; k++)
                    begin
                        if (cfg_index == llba_pkg::REG_MU_BASE + llba_pkg::CFG_IDX_W'(k))
                        begin
                            mu_reg[k] <= cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    // row checks at acceptance
    assign has_in     = {has_c, has_b, has_a};
    assign cost_in[0] = cost_a & COST_MASK;
    assign cost_in[1] = cost_b & COST_MASK;
    assign cost_in[2] = cost_c & COST_MASK;
    assign prefix_in  = CMP_W'(row_idx_reg) < CMP_W'(pfx_reg);
    assign bad_cfg    = (scale_reg == '0) || (thr_reg >= scale_reg) || (q_reg == '0);

    always_comb
    begin
        case (fixed_method)
            2'd1:    bad_pfx = !has_in[0];
            2'd2:    bad_pfx = !has_in[1];
            2'd3:    bad_pfx = !has_in[2];
            default: bad_pfx = 1'b1;
        endcase
        if (has_in == '0)
        begin
            pre_err_in = llba_pkg::STS_ROW_EMPTY;
        end
        else if (prefix_in && bad_pfx)
        begin
            pre_err_in = llba_pkg::STS_BAD_PFX;
        end
        else if (bad_cfg)
        begin
            pre_err_in = llba_pkg::STS_BAD_CFG;
        end
        else
        begin
            pre_err_in = llba_pkg::STS_OK;
        end
    end

    always_comb
    begin
        case (fm_reg)
            2'd1:    fm_sel = 3'b001;
            2'd2:    fm_sel = 3'b010;
            2'd3:    fm_sel = 3'b100;
            default: fm_sel = 3'b000;
        endcase
    end

    assign active = prefix_reg ? (has_reg & fm_sel) : has_reg;
    assign fac_ab = scale_reg - thr_reg;

    // state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            llba_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = llba_pkg::ST_RUN;
                end
            end
            llba_pkg::ST_RUN:
            begin
                if (merged.valid && (merged.k == GW'(GRID - 1)))
                begin
                    state_next = llba_pkg::ST_COMMIT;
                end
            end
            llba_pkg::ST_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = llba_pkg::ST_IDLE;
                end
            end
            default: state_next = llba_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        issue     = 1'b0;
        commit_go = !last_reg || !out_valid_reg || !out_stall;
        commit    = 1'b0;
        unique case (state_reg)
            llba_pkg::ST_IDLE:   in_stall = 1'b0;
            llba_pkg::ST_RUN:    issue = issue_cnt_reg < (GW+1)'(GRID);
            llba_pkg::ST_COMMIT: commit = commit_go;
            default:             in_stall = 1'b1;
        endcase
    end

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= llba_pkg::ST_IDLE;
            issue_cnt_reg <= '0;
            row_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                issue_cnt_reg <= '0;
                row_ovf_reg   <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (merged.valid)
                begin
                    row_ovf_reg <= row_ovf_reg | merged.ovf;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int m = 0; m < NL; m++)
            begin
                cost_reg[m] <= cost_in[m];
            end
            has_reg      <= has_in;
            fm_reg       <= fixed_method;
            last_reg     <= last_row;
            prefix_reg   <= prefix_in;
            pre_err_reg  <= pre_err_in;
            too_many_reg <= row_idx_reg >= RIDX_W'(ROW_CAPACITY);
        end
        if (merged.valid)
        begin
            score_reg[merged.k] <= merged.best;
        end
    end

    // method lanes
    for (genvar m = 0; m < NL; m++)
    begin : g_lane
        llba_lane u_lane
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .issue    (issue),
            .issue_k  (issue_cnt_reg[GW-1:0]),
            .add_term (m == NL - 1),
            .cost     (cost_reg[m]),
            .mu       (mu_reg[issue_cnt_reg[GW-1:0]]),
            .q_factor (q_reg),
            .factor   ((m == NL - 1) ? thr_reg : fac_ab),
            .res      (lane_res[m])
        );
    end

    llba_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .lane_res (lane_res),
        .active   (active),
        .merged   (merged)
    );

    // commit of one row
    always_comb
    begin
        if (pre_err_reg != llba_pkg::STS_OK)
        begin
            row_err = pre_err_reg;
        end
        else if (row_ovf_reg)
        begin
            row_err = llba_pkg::STS_SCORE_OVF;
        end
        else
        begin
            row_err = llba_pkg::STS_OK;
        end
        row_idx_next   = row_idx_reg;
        first_err_next = first_err_reg;
        for (int k = 0; k < GRID; k++)
        begin
            sum_next[k] = sum_reg[k];
        end
        if (too_many_reg)
        begin
            if (first_err_reg == llba_pkg::STS_OK)
            begin
                first_err_next = llba_pkg::STS_BOUND_OVF;
            end
        end
        else
        begin
            row_idx_next = row_idx_reg + 1'b1;
            if (first_err_reg == llba_pkg::STS_OK)
            begin
                if (row_err != llba_pkg::STS_OK)
                begin
                    first_err_next = row_err;
                end
                else
                begin
                    for (int k = 0; k < GRID; k++)
                    begin
                        sum_next[k] = sum_reg[k] + {{(llba_pkg::SUM_W-64){score_reg[k][63]}},
                                                    score_reg[k]};
                    end
                end
            end
        end
        if (CMP_W'(row_idx_next) < CMP_W'(pfx_reg))
        begin
            status_c = llba_pkg::STS_TOO_FEW;
        end
        else
        begin
            status_c = first_err_next;
        end
        if (status_c == llba_pkg::STS_OK)
        begin
            for (int k = 0; k < GRID; k++)
            begin
                if (!((sum_next[k][llba_pkg::SUM_W-1:63] == '0) ||
                      (sum_next[k][llba_pkg::SUM_W-1:63] == '1)))
                begin
                    status_c = llba_pkg::STS_BOUND_OVF;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_idx_reg   <= '0;
            first_err_reg <= llba_pkg::STS_OK;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < GRID; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                if (last_reg)
                begin
                    row_idx_reg   <= '0;
                    first_err_reg <= llba_pkg::STS_OK;
                    out_valid_reg <= 1'b1;
                    for (int k = 0; k < GRID; k++)
                    begin
                        sum_reg[k] <= '0;
                    end
                end
                else
                begin
                    row_idx_reg   <= row_idx_next;
                    first_err_reg <= first_err_next;
                    for (int k = 0; k < GRID; k++)
                    begin
                        sum_reg[k] <= sum_next[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && last_reg)
        begin
            status_reg <= status_c;
            for (int k = 0; k < GRID; k++)
            begin
                bound_reg[k] <= (status_c == llba_pkg::STS_OK) ? sum_next[k][63:0] : 64'd0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign bound_0   = bound_reg[0];
    assign bound_1   = bound_reg[1];
    assign bound_2   = bound_reg[2];
    assign bound_3   = bound_reg[3];

    `LLBA_ASSERT_IMP(a_rise_from_commit, $rose(out_valid_reg),
                     $past(state_reg) == llba_pkg::ST_COMMIT)
    `LLBA_ASSERT_IMP(a_merge_in_run, merged.valid, state_reg == llba_pkg::ST_RUN)
    `LLBA_ASSERT_NXT(a_clear_after_last, commit && last_reg,
                     (row_idx_reg == '0) && (first_err_reg == llba_pkg::STS_OK))
    `LLBA_ASSERT_IMP(a_fail_zero_bounds,
                     out_valid_reg && (status_reg != llba_pkg::STS_OK),
                     (bound_reg[0] == '0) && (bound_reg[1] == '0) &&
                     (bound_reg[2] == '0) && (bound_reg[3] == '0))

endmodule

FILE: dv/tb_lagrangian_lower_bound_accumulator.sv
// testbench of the lagrangian lower bound accumulator: random and directed rows,
// an in-file predictor of scores, sums and status, scoreboard on the result channel
// depends on llba_pkg and the lagrangian_lower_bound_accumulator rtl
module tb_lagrangian_lower_bound_accumulator;

    localparam int ROW_LIMIT  = 4096;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [31:0] cost [3];
        logic        has [3];
        logic [1:0]  fm;
        logic        last;
    } row_t;

    typedef struct {
        logic [63:0]                   bound [llba_pkg::GRID_SIZE];
        logic [llba_pkg::STATUS_W-1:0] sts;
    } bound_set_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [llba_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [llba_pkg::CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [31:0] cost_a, cost_b, cost_c;
    logic has_a, has_b, has_c;
    logic [1:0] fixed_method;
    logic last_row;
    logic out_valid;
    logic out_stall;
    logic signed [63:0] bound_0, bound_1, bound_2, bound_3;
    logic [llba_pkg::STATUS_W-1:0] status;

    lagrangian_lower_bound_accumulator i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cost_a(cost_a), .cost_b(cost_b), .cost_c(cost_c),
        .has_a(has_a), .has_b(has_b), .has_c(has_c),
        .fixed_method(fixed_method), .last_row(last_row),
        .out_valid(out_valid), .out_stall(out_stall),
        .bound_0(bound_0), .bound_1(bound_1), .bound_2(bound_2), .bound_3(bound_3),
        .status(status)
    );

    row_t       pending_rows [$];
    bound_set_t expected_bounds [$];
    row_t       driven_row;
    int         fail_count;
    int         cycle_count;
    int         quiet_cycles;

    logic [31:0] thr_r, scl_r;
    logic [62:0] q_r;
    logic [12:0] pfx_r;
    logic [62:0] mu_r [llba_pkg::GRID_SIZE];
    logic signed [llba_pkg::SUM_W-1:0] acc [llba_pkg::GRID_SIZE];
    int          rows_taken;
    logic [llba_pkg::STATUS_W-1:0] sticky_err;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // score of one method; returns 0 when it leaves the signed 64-bit range
    function automatic logic method_score(input logic [31:0] c, input int m,
                                          input logic [62:0] mk, output logic [63:0] s);
        logic [129:0] a, b, d, cv, fv, mv;
        cv = 130'(c);
        mv = 130'(mk);
        a = 130'(q_r);
        a = a * cv;
        fv = (m < 2) ? 130'(scl_r - thr_r) : 130'(thr_r);
        b = mv * cv * fv;
        s = '0;
        if (m == 2)
        begin
            d = a + b;
            if (d > 130'h7FFF_FFFF_FFFF_FFFF) return 1'b0;
            s = d[63:0];
            return 1'b1;
        end
        if (a >= b)
        begin
            d = a - b;
            if (d > 130'h7FFF_FFFF_FFFF_FFFF) return 1'b0;
            s = d[63:0];
        end
        else
        begin
            d = b - a;
            if (d > 130'h8000_0000_0000_0000) return 1'b0;
            s = 64'd0 - d[63:0];
        end
        return 1'b1;
    endfunction

    function automatic logic [llba_pkg::STATUS_W-1:0] row_scores(input row_t r,
        output logic [63:0] sc [llba_pkg::GRID_SIZE]);
        logic        in_prefix;
        logic        found;
        logic [63:0] best, s;
        in_prefix = rows_taken < pfx_r;
        for (int k = 0; k < llba_pkg::GRID_SIZE; k++) sc[k] = '0;
        if (!r.has[0] && !r.has[1] && !r.has[2]) return llba_pkg::STS_ROW_EMPTY;
        if (in_prefix && (r.fm == 2'd0 || !r.has[r.fm - 1])) return llba_pkg::STS_BAD_PFX;
        if (scl_r == 0 || thr_r >= scl_r || q_r == 0) return llba_pkg::STS_BAD_CFG;
        for (int k = 0; k < llba_pkg::GRID_SIZE; k++)
        begin
            found = 1'b0;
            best = '0;
            for (int m = 0; m < 3; m++)
            begin
                if (in_prefix && m != int'(r.fm) - 1) continue;
                if (!r.has[m]) continue;
                if (!method_score(r.cost[m], m, mu_r[k], s)) return llba_pkg::STS_SCORE_OVF;
                if (!found || $signed(s) < $signed(best)) best = s;
                found = 1'b1;
            end
            sc[k] = best;
        end
        return llba_pkg::STS_OK;
    endfunction

    function automatic void clear_sums();
        for (int k = 0; k < llba_pkg::GRID_SIZE; k++) acc[k] = '0;
        rows_taken = 0;
        sticky_err = llba_pkg::STS_OK;
    endfunction

    function automatic void accumulate_row(input row_t r);
        logic [63:0]                   sc [llba_pkg::GRID_SIZE];
        logic [llba_pkg::STATUS_W-1:0] e;
        bound_set_t                    res;
        if (rows_taken >= ROW_LIMIT)
        begin
            if (sticky_err == llba_pkg::STS_OK) sticky_err = llba_pkg::STS_BOUND_OVF;
        end
        else
        begin
            e = row_scores(r, sc);
            rows_taken++;
            if (sticky_err == llba_pkg::STS_OK)
            begin
                if (e != llba_pkg::STS_OK) sticky_err = e;
                else
                    for (int k = 0; k < llba_pkg::GRID_SIZE; k++)
                        acc[k] = acc[k] + {{13{sc[k][63]}}, sc[k]};
            end
        end
        if (!r.last) return;
        res.sts = (rows_taken < pfx_r) ? llba_pkg::STS_TOO_FEW : sticky_err;
        if (res.sts == llba_pkg::STS_OK)
            for (int k = 0; k < llba_pkg::GRID_SIZE; k++)
                if (acc[k] != {{13{acc[k][63]}}, acc[k][63:0]})
                    res.sts = llba_pkg::STS_BOUND_OVF;
        for (int k = 0; k < llba_pkg::GRID_SIZE; k++)
            res.bound[k] = (res.sts == llba_pkg::STS_OK) ? acc[k][63:0] : 64'd0;
        expected_bounds.insert(expected_bounds.size(), res);
        clear_sums();
    endfunction

    function automatic logic quiet_stretch();
        return (cycle_count % 5000) < 1500;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid) accumulate_row(driven_row);
            if (pending_rows.size() > 0 && (quiet_stretch() || $urandom_range(99) >= 7))
            begin
                driven_row = pending_rows.pop_front();
                in_valid <= 1'b1;
                cost_a <= driven_row.cost[0];
                cost_b <= driven_row.cost[1];
                cost_c <= driven_row.cost[2];
                has_a <= driven_row.has[0];
                has_b <= driven_row.has[1];
                has_c <= driven_row.has[2];
                fixed_method <= driven_row.fm;
                last_row <= driven_row.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        bound_set_t  e;
        logic [63:0] got [llba_pkg::GRID_SIZE];
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= !quiet_stretch() && $urandom_range(99) < 7;
            if (out_valid && !out_stall)
            begin
                got[0] = bound_0;
                got[1] = bound_1;
                got[2] = bound_2;
                got[3] = bound_3;
                if (expected_bounds.size() == 0)
                begin
                    $error("unexpected result transaction, status %0d", status);
                    fail_count++;
                end
                else
                begin
                    e = expected_bounds.pop_front();
                    for (int k = 0; k < llba_pkg::GRID_SIZE; k++)
                        if (got[k] !== e.bound[k])
                        begin
                            $error("bound_%0d expected %0d actual %0d", k,
                                   $signed(e.bound[k]), $signed(got[k]));
                            fail_count++;
                        end
                    if (status !== e.sts)
                    begin
                        $error("status expected %0d actual %0d", e.sts, status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [llba_pkg::CFG_IDX_W-1:0] idx,
                             input logic [62:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            llba_pkg::REG_THRESHOLD: thr_r = val[31:0];
            llba_pkg::REG_SCALE:     scl_r = val[31:0];
            llba_pkg::REG_Q_FACTOR:  q_r = val;
            llba_pkg::REG_PREFIX:    pfx_r = val[12:0];
            default:                 mu_r[idx - llba_pkg::REG_MU_BASE] = val;
        endcase
    endtask

    task automatic configure(input logic [31:0] thr, input logic [31:0] scl,
                             input logic [62:0] q, input logic [12:0] pfx,
                             input logic [62:0] m0, input logic [62:0] m1,
                             input logic [62:0] m2, input logic [62:0] m3);
        write_reg(llba_pkg::REG_THRESHOLD, 63'(thr));
        write_reg(llba_pkg::REG_SCALE, 63'(scl));
        write_reg(llba_pkg::REG_Q_FACTOR, q);
        write_reg(llba_pkg::REG_PREFIX, 63'(pfx));
        write_reg(llba_pkg::REG_MU_BASE, m0);
        write_reg(llba_pkg::REG_MU_BASE + 4'd1, m1);
        write_reg(llba_pkg::REG_MU_BASE + 4'd2, m2);
        write_reg(llba_pkg::REG_MU_BASE + 4'd3, m3);
    endtask

    task automatic drain();
        while (in_valid || pending_rows.size() > 0 || expected_bounds.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_cost(input int mode);
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return (mode == 0) ? $urandom_range(1000) : $urandom;
        endcase
    endfunction

    task automatic queue_row(input logic [31:0] ca, input logic [31:0] cb,
                             input logic [31:0] cc, input logic [2:0] hv,
                             input logic [1:0] fm, input logic last);
        row_t r;
        r.cost[0] = ca;
        r.cost[1] = cb;
        r.cost[2] = cc;
        r.has[0] = hv[0];
        r.has[1] = hv[1];
        r.has[2] = hv[2];
        r.fm = fm;
        r.last = last;
        pending_rows.insert(pending_rows.size(), r);
    endtask

    // mostly well-formed sets: prefix rows name an available method, few empty rows
    task automatic push_set(input int n, input int mode);
        logic [2:0] hv;
        logic [1:0] fm;
        for (int i = 0; i < n; i++)
        begin
            hv = 3'($urandom_range(7));
            fm = 2'($urandom_range(3));
            if (i < pfx_r && $urandom_range(19) != 0)
            begin
                fm = 2'($urandom_range(1, 3));
                hv[fm - 1] = 1'b1;
            end
            else if (hv == 3'd0 && $urandom_range(9) != 0)
            begin
                hv = 3'd7;
            end
            queue_row(pick_cost(mode), pick_cost(mode), pick_cost(mode), hv, fm, i == n - 1);
        end
    endtask

    initial
    begin
        logic [31:0] t;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cost_a = '0;
        cost_b = '0;
        cost_c = '0;
        has_a = 1'b0;
        has_b = 1'b0;
        has_c = 1'b0;
        fixed_method = '0;
        last_row = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        quiet_cycles = 0;
        thr_r = '0;
        scl_r = 32'd1;
        q_r = 63'd1;
        pfx_r = '0;
        for (int k = 0; k < llba_pkg::GRID_SIZE; k++) mu_r[k] = '0;
        clear_sums();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset configuration
        queue_row(32'd0, 32'd0, 32'd0, 3'b111, 2'd0, 1'b1);
        queue_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111, 2'd3, 1'b1);
        queue_row(32'd5, 32'd0, 32'd0, 3'b001, 2'd1, 1'b0);
        queue_row(32'd0, 32'd9, 32'd0, 3'b010, 2'd2, 1'b0);
        queue_row(32'd0, 32'd0, 32'd7, 3'b100, 2'd3, 1'b1);
        queue_row(32'd1, 32'd2, 32'd3, 3'b000, 2'd0, 1'b0);
        queue_row(32'd1, 32'd2, 32'd3, 3'b111, 2'd0, 1'b1);
        drain();

        // directed, prefix and mixed methods
        configure(32'd3, 32'd10, 63'd5, 13'd2, 63'd0, 63'd1, 63'd7, 63'd100);
        queue_row(32'd10, 32'd20, 32'd30, 3'b111, 2'd3, 1'b0);
        queue_row(32'd10, 32'd20, 32'd30, 3'b111, 2'd1, 1'b0);
        queue_row(32'd10, 32'd2, 32'd30, 3'b111, 2'd0, 1'b1);
        queue_row(32'd4, 32'd4, 32'd4, 3'b111, 2'd0, 1'b1);
        queue_row(32'd4, 32'd4, 32'd4, 3'b101, 2'd2, 1'b1);
        queue_row(32'd4, 32'd4, 32'd4, 3'b111, 2'd2, 1'b1);
        drain();

        // directed, bad configurations
        configure(32'd5, 32'd5, 63'd1, 13'd0, 63'd1, 63'd1, 63'd1, 63'd1);
        queue_row(32'd1, 32'd1, 32'd1, 3'b111, 2'd1, 1'b1);
        drain();
        write_reg(llba_pkg::REG_SCALE, 63'd0);
        write_reg(llba_pkg::REG_THRESHOLD, 63'd0);
        queue_row(32'd1, 32'd1, 32'd1, 3'b111, 2'd1, 1'b1);
        drain();
        configure(32'd0, 32'd1, 63'd0, 13'd0, 63'd1, 63'd1, 63'd1, 63'd1);
        queue_row(32'd1, 32'd1, 32'd1, 3'b111, 2'd1, 1'b1);
        drain();

        // extremes: score overflow, then bound overflow
        configure(32'hFFFF_FFFE, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 13'd0,
                  63'h7FFF_FFFF_FFFF_FFFF, 63'd0, 63'd1, 63'h7FFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 6; i++) push_set($urandom_range(1, 3), 1);
        queue_row(32'd0, 32'd0, 32'd0, 3'b111, 2'd0, 1'b1);
        queue_row(32'd1, 32'd1, 32'd1, 3'b011, 2'd0, 1'b1);
        drain();
        configure(32'd0, 32'd1, 63'h4000_0000, 13'd0, 63'd0, 63'd0, 63'd0, 63'd0);
        for (int i = 0; i < 3; i++)
            queue_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111, 2'd0, i == 2);
        for (int i = 0; i < 8; i++) push_set($urandom_range(1, 6), 1);
        drain();

        // prefix at row capacity: too few rows
        configure(32'd1, 32'd3, 63'd2, 13'd4096, 63'd1, 63'd2, 63'd3, 63'd4);
        push_set(5, 0);
        drain();
        write_reg(llba_pkg::REG_PREFIX, 63'd0);

        // random configurations
        for (int p = 0; p < 12; p++)
        begin
            t = $urandom_range(1000);
            configure(t, t + 32'($urandom_range(1, 1000)), 63'($urandom_range(1, 1 << 20)),
                      13'($urandom_range(4)),
                      ($urandom_range(7) == 0) ? 63'({$urandom, $urandom})
                                               : 63'($urandom_range(65535)),
                      63'($urandom_range(65535)), 63'($urandom_range(255)),
                      ($urandom_range(7) == 0) ? 63'd0 : 63'($urandom_range(65535)));
            for (int n = 0; n < 150; )
            begin
                t = $urandom_range(1, 12);
                push_set(t, $urandom_range(1));
                n += t;
            end
            drain();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/llba_pkg.sv
design/llba_lane.sv
design/llba_merge.sv
design/lagrangian_lower_bound_accumulator.sv
dv/tb_lagrangian_lower_bound_accumulator.sv
